FILE: rtl/set_assoc_lru_value_cache_top_assert.svh
// Assertion shorthands shared by the cache RTL.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef SET_ASSOC_LRU_VALUE_CACHE_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_VALUE_CACHE_TOP_ASSERT_SVH

// Same-cycle implication
`define SALVC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SALVC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/salvc_pkg.sv
package salvc_pkg;

	// Payload widths
	localparam int PC_W      = 64;
	localparam int DATA_W    = 32;
	localparam int KEY_SHIFT = 2;
	localparam int KEY_W     = PC_W - KEY_SHIFT;

	// Operation codes
	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;

	// Outcome of one set access, from the way logic to the sequencer
	typedef struct packed {
		logic                     wr;
		logic                     hit;
		logic signed [DATA_W-1:0] diff_out;
	} salvc_res_t;

endpackage

FILE: rtl/salvc_req_if.sv
interface salvc_req_if import salvc_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic        [PC_W-1:0]   pc;
	logic signed [DATA_W-1:0] diff_in;

	modport source (output valid, output func, output pc, output diff_in, input ready);
	modport sink (input valid, input func, input pc, input diff_in, output ready);
endinterface

FILE: rtl/salvc_rsp_if.sv
interface salvc_rsp_if import salvc_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic signed [DATA_W-1:0] diff_out;

	modport source (output valid, output hit, output diff_out, input ready);
	modport sink (input valid, input hit, input diff_out, output ready);
endinterface

FILE: rtl/set_assoc_lru_value_cache_top.sv
// Channel  Dir  Payload                      Transfer
// req      in   func, pc[63:0], diff_in[31:0] valid && ready
// rsp      out  hit, diff_out[31:0]           valid && ready
//
// Each item reads its set row from the RAM, then updates the row, writes it back
// and loads the response register; no new request is taken until that is done.
// SET_CNT must be a power of two; bits [log2(SET_CNT)+1:2] of pc pick the set.
// After reset a clearing pass writes every set row, with req held off.
// A response waiting in the output register holds off req only until it is taken.
module set_assoc_lru_value_cache_top import salvc_pkg::*; #(
	parameter int SET_CNT = 256,
	parameter int ASSOC    = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	salvc_req_if.sink    req,
	salvc_rsp_if.source  rsp
);

	`include "set_assoc_lru_value_cache_top_assert.svh"

	localparam int LOG_N  = $clog2(SET_CNT);
	localparam int IDX_W  = (SET_CNT > 1) ? LOG_N : 1;
	localparam int TAG_W  = KEY_W - LOG_N;
	localparam int RANK_W = (ASSOC > 1) ? $clog2(ASSOC) : 1;
	localparam int ROW_W  = ASSOC * (1 + TAG_W + DATA_W + RANK_W);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK} state_t;

	state_t                    state_q;
	logic [IDX_W-1:0]          clr_q;
	logic                      rsp_valid_q;
	logic                      hit_q;
	logic signed [DATA_W-1:0]  diff_out_q;

	logic                      func_s1;
	logic [TAG_W-1:0]          tag_s1;
	logic [IDX_W-1:0]          set_s1;
	logic signed [DATA_W-1:0]  diff_s1;

	logic [KEY_W-1:0]          key;
	logic [IDX_W-1:0]          set_in;
	logic                      accept;
	logic                      wr_en;
	logic [IDX_W-1:0]          waddr;
	logic [ROW_W-1:0]          row_rd;
	logic [ROW_W-1:0]          row_wr;
	logic [ROW_W-1:0]          wdata;

	logic [ASSOC-1:0]              valid_rd, valid_wr;
	logic [ASSOC-1:0][TAG_W-1:0]   tag_rd, tag_wr;
	logic [ASSOC-1:0][DATA_W-1:0]  value_rd, value_wr;
	logic [ASSOC-1:0][RANK_W-1:0]  rank_rd, rank_wr;
	salvc_res_t                    res;

	// Split the key into set index and tag
	assign key    = req.pc[PC_W-1:KEY_SHIFT];
	assign set_in = (SET_CNT > 1) ? key[IDX_W-1:0] : '0;

	// Take a request only when idle and the response register can take the result
	assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// Write clear rows during the pass, else the updated row
	assign wr_en = (state_q == ST_CLEAR) || ((state_q == ST_LOOK) && res.wr);
	assign waddr = (state_q == ST_CLEAR) ? clr_q : set_s1;
	assign row_wr = {valid_wr, tag_wr, value_wr, rank_wr};
	assign wdata  = (state_q == ST_CLEAR) ? '0 : row_wr;
	assign {valid_rd, tag_rd, value_rd, rank_rd} = row_rd;

	salvc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SET_CNT)
	) u_row_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept),
		.raddr (set_in),
		.rdata (row_rd)
	);

	salvc_way_upd #(
		.ASSOC (ASSOC),
		.TAG_W (TAG_W)
	) u_way_upd (
		.func     (func_s1),
		.tag_in   (tag_s1),
		.diff_in  (diff_s1),
		.valid_rd (valid_rd),
		.tag_rd   (tag_rd),
		.value_rd (value_rd),
		.rank_rd  (rank_rd),
		.valid_wr (valid_wr),
		.tag_wr   (tag_wr),
		.value_wr (value_wr),
		.rank_wr  (rank_wr),
		.res      (res)
	);

	// Hold the request fields for the update cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= req.func;
			tag_s1  <= key[KEY_W-1:LOG_N];
			set_s1  <= set_in;
			diff_s1 <= req.diff_in;
		end
	end

	// Sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			diff_out_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(SET_CNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_IDLE;
				end
			endcase
			// drop the response once transferred, load a fresh one after the update
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == ST_LOOK) begin
				rsp_valid_q <= 1'b1;
				hit_q       <= res.hit;
				diff_out_q  <= res.diff_out;
			end
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.hit      = hit_q;
	assign rsp.diff_out = diff_out_q;

	`SALVC_ASSERT_NOW(a_look_out_free, state_q == ST_LOOK, !rsp_valid_q, "result lands on a busy response register")
	`SALVC_ASSERT_NEXT(a_look_gives_rsp, state_q == ST_LOOK, rsp_valid_q, "update cycle produced no response")
	`SALVC_ASSERT_NOW(a_no_idle_write, state_q == ST_IDLE, !wr_en, "RAM written while idle")
	`SALVC_ASSERT_NOW(a_miss_no_write, (state_q == ST_LOOK) && (func_s1 == FUNC_LOOKUP) && !res.hit, !wr_en, "lookup miss wrote the set")

endmodule

FILE: rtl/salvc_ram.sv
module salvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/salvc_way_upd.sv
module salvc_way_upd import salvc_pkg::*; #(
	parameter int ASSOC = 4,
	parameter int TAG_W = 54,
	localparam int RANK_W = (ASSOC > 1) ? $clog2(ASSOC) : 1
) (
	input  logic                               func,
	input  logic [TAG_W-1:0]                   tag_in,
	input  logic signed [DATA_W-1:0]           diff_in,
	input  logic [ASSOC-1:0]                   valid_rd,
	input  logic [ASSOC-1:0][TAG_W-1:0]        tag_rd,
	input  logic [ASSOC-1:0][DATA_W-1:0]       value_rd,
	input  logic [ASSOC-1:0][RANK_W-1:0]       rank_rd,
	output logic [ASSOC-1:0]                   valid_wr,
	output logic [ASSOC-1:0][TAG_W-1:0]        tag_wr,
	output logic [ASSOC-1:0][DATA_W-1:0]       value_wr,
	output logic [ASSOC-1:0][RANK_W-1:0]       rank_wr,
	output salvc_res_t                         res
);

	localparam int WAY_W = (ASSOC > 1) ? $clog2(ASSOC) : 1;
	localparam int OLD_W = RANK_W + 1;
	localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(ASSOC - 1);
	localparam logic [OLD_W-1:0]  OLD_NONE  = OLD_W'(ASSOC);

	logic [ASSOC-1:0] match;
	logic             hit;
	logic             full;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] lru_way;
	logic [WAY_W-1:0] tgt;
	logic [OLD_W-1:0] old;

	// Tag compare and way selection
	always_comb begin
		match    = '0;
		hit_way  = '0;
		free_way = '0;
		lru_way  = '0;
		for (int i = 0; i < ASSOC; i++) begin
			match[i] = valid_rd[i] && (tag_rd[i] == tag_in);
		end
		// scan downwards so the lowest way wins
		for (int i = ASSOC - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_way = WAY_W'(i);
			end
			if (!valid_rd[i]) begin
				free_way = WAY_W'(i);
			end
			// in a full set the ranks are a permutation, so the oldest is unique
			if (rank_rd[i] == LAST_RANK) begin
				lru_way = WAY_W'(i);
			end
		end
		hit  = |match;
		full = &valid_rd;
		if (hit) begin
			tgt = hit_way;
		end else if (full) begin
			tgt = lru_way;
		end else begin
			tgt = free_way;
		end
	end

	// Build the write-back row: age younger ways, refresh the target
	always_comb begin
		old      = valid_rd[tgt] ? {1'b0, rank_rd[tgt]} : OLD_NONE;
		valid_wr = valid_rd;
		tag_wr   = tag_rd;
		value_wr = value_rd;
		rank_wr  = rank_rd;
		for (int i = 0; i < ASSOC; i++) begin
			if ((WAY_W'(i) != tgt) && valid_rd[i] && ({1'b0, rank_rd[i]} < old)) begin
				rank_wr[i] = rank_rd[i] + 1'b1;
			end
		end
		rank_wr[tgt] = '0;
		if (func == FUNC_UPDATE) begin
			valid_wr[tgt] = 1'b1;
			tag_wr[tgt]   = tag_in;
			value_wr[tgt] = diff_in;
		end
		res.hit      = hit;
		res.wr       = (func == FUNC_UPDATE) || hit;
		res.diff_out = ((func == FUNC_LOOKUP) && hit) ? $signed(value_rd[hit_way]) : '0;
	end

endmodule
